[rtl/core/lorenz_euler_step_plotter_core_assert.svh]
`ifndef LORENZ_EULER_STEP_PLOTTER_CORE_ASSERT_SVH
`define LORENZ_EULER_STEP_PLOTTER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LESP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LESP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lesp_pkg.sv]
package lesp_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STEP_W     = 25;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned PIX_W      = 11;

  // register reset values, raw fixed point
  localparam logic signed [DATA_W-1:0] RST_SIGMA   = 32'sd167772160;
  localparam logic signed [DATA_W-1:0] RST_RHO     = 32'sd469762048;
  localparam logic signed [DATA_W-1:0] RST_BETA    = 32'sd44739243;
  localparam logic [STEP_W-1:0]        RST_STEP    = 25'd167772;
  localparam logic signed [DATA_W-1:0] RST_START_X = 32'sd16777216;
  localparam logic signed [DATA_W-1:0] RST_START_Y = 32'sd16777216;
  localparam logic signed [DATA_W-1:0] RST_START_Z = 32'sd16777216;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIGMA,
    REG_RHO,
    REG_BETA,
    REG_STEP_SIZE,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_SA,
    ST_MUL_XE,
    ST_MUL_BZ,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_MUL_DZ,
    ST_WB_DZ,
    ST_UPDATE,
    ST_OUTPUT
  } state_e;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X_Y,
    MUL_SIGMA_A,
    MUL_X_E,
    MUL_BETA_Z,
    MUL_DT_T1,
    MUL_DT_Q1,
    MUL_DT_Q2
  } mul_sel_e;

  // destination of the registered product
  typedef enum logic [2:0] {
    WB_NONE,
    WB_T3,
    WB_T1,
    WB_T2,
    WB_T4,
    WB_DX,
    WB_DY,
    WB_DZ
  } wb_sel_e;

  typedef struct packed {
    logic     start;
    logic     diff;
    logic     q1;
    logic     q2;
    logic     update;
    logic     out_load;
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic ovf33(input logic signed [DATA_W:0] v);
    return v[DATA_W] ^ v[DATA_W-1];
  endfunction

endpackage

[rtl/core/lesp_ctrl.sv]
module lesp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lesp_pkg::cmd_t  cmd_o
);

  lesp_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lesp_pkg::ST_IDLE:   if (in_valid_i) state_d = lesp_pkg::ST_DIFF;
      lesp_pkg::ST_DIFF:   state_d = lesp_pkg::ST_MUL_SA;
      lesp_pkg::ST_MUL_SA: state_d = lesp_pkg::ST_MUL_XE;
      lesp_pkg::ST_MUL_XE: state_d = lesp_pkg::ST_MUL_BZ;
      lesp_pkg::ST_MUL_BZ: state_d = lesp_pkg::ST_MUL_DX;
      lesp_pkg::ST_MUL_DX: state_d = lesp_pkg::ST_MUL_DY;
      lesp_pkg::ST_MUL_DY: state_d = lesp_pkg::ST_MUL_DZ;
      lesp_pkg::ST_MUL_DZ: state_d = lesp_pkg::ST_WB_DZ;
      lesp_pkg::ST_WB_DZ:  state_d = lesp_pkg::ST_UPDATE;
      lesp_pkg::ST_UPDATE: state_d = lesp_pkg::ST_OUTPUT;
      lesp_pkg::ST_OUTPUT: if (out_free) state_d = lesp_pkg::ST_IDLE;
      default:             state_d = lesp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = lesp_pkg::MUL_NONE;
    cmd_o.wb_sel  = lesp_pkg::WB_NONE;
    in_ready_o    = 1'b0;
    case (state_q)
      lesp_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      lesp_pkg::ST_DIFF: begin
        cmd_o.diff    = 1'b1;
        cmd_o.mul_sel = lesp_pkg::MUL_X_Y;
      end
      lesp_pkg::ST_MUL_SA: begin
        cmd_o.mul_sel = lesp_pkg::MUL_SIGMA_A;
        cmd_o.wb_sel  = lesp_pkg::WB_T3;
      end
      lesp_pkg::ST_MUL_XE: begin
        cmd_o.mul_sel = lesp_pkg::MUL_X_E;
        cmd_o.wb_sel  = lesp_pkg::WB_T1;
      end
      lesp_pkg::ST_MUL_BZ: begin
        cmd_o.mul_sel = lesp_pkg::MUL_BETA_Z;
        cmd_o.wb_sel  = lesp_pkg::WB_T2;
      end
      lesp_pkg::ST_MUL_DX: begin
        cmd_o.q1      = 1'b1;
        cmd_o.mul_sel = lesp_pkg::MUL_DT_T1;
        cmd_o.wb_sel  = lesp_pkg::WB_T4;
      end
      lesp_pkg::ST_MUL_DY: begin
        cmd_o.q2      = 1'b1;
        cmd_o.mul_sel = lesp_pkg::MUL_DT_Q1;
        cmd_o.wb_sel  = lesp_pkg::WB_DX;
      end
      lesp_pkg::ST_MUL_DZ: begin
        cmd_o.mul_sel = lesp_pkg::MUL_DT_Q2;
        cmd_o.wb_sel  = lesp_pkg::WB_DY;
      end
      lesp_pkg::ST_WB_DZ: begin
        cmd_o.wb_sel = lesp_pkg::WB_DZ;
      end
      lesp_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      lesp_pkg::ST_OUTPUT: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lesp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/lesp_dpath.sv]
module lesp_dpath #(
  parameter int unsigned FRAC_BITS     = 24,
  parameter int unsigned SCREEN_WIDTH  = 1920,
  parameter int unsigned SCREEN_HEIGHT = 1080
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lesp_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [lesp_pkg::DATA_W-1:0]            cfg_data_i,
  input  logic                                   restart_i,
  input  lesp_pkg::cmd_t                         cmd_i,
  output logic signed [lesp_pkg::DATA_W-1:0]     pos_x_o,
  output logic signed [lesp_pkg::DATA_W-1:0]     pos_y_o,
  output logic signed [lesp_pkg::DATA_W-1:0]     pos_z_o,
  output logic [lesp_pkg::PIX_W-1:0]             pixel_col_o,
  output logic [lesp_pkg::PIX_W-1:0]             pixel_row_o,
  output logic                                   on_screen_o,
  output logic                                   still_moving_o,
  output logic                                   overflowed_o
);

  localparam int unsigned W  = lesp_pkg::DATA_W;
  localparam int unsigned PW = 2 * W + 2;

  localparam logic signed [39:0] ColCenter = 40'(SCREEN_WIDTH / 2);
  localparam logic signed [39:0] RowCenter = 40'(SCREEN_HEIGHT / 2);
  localparam logic signed [39:0] ColLast   = 40'(SCREEN_WIDTH - 1);
  localparam logic signed [39:0] RowLast   = 40'(SCREEN_HEIGHT - 1);
  localparam logic [W+1:0]       MoveMin   =
    (W+2)'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [47:0] CoordMax  = 48'sd100 <<< FRAC_BITS;

  // configuration
  logic signed [W-1:0]              sigma_q, rho_q, beta_q;
  logic [lesp_pkg::STEP_W-1:0]      step_size_q;
  logic signed [W-1:0]              start_x_q, start_y_q, start_z_q;

  // state and intermediates
  logic signed [W-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic signed [W-1:0] a_q, e_q, t1_q, t2_q, t3_q, t4_q, q1_q, q2_q;
  logic signed [W-1:0] dx_q, dy_q, dz_q;
  logic                ovf_q, ovf_d;

  logic signed [W:0]    mul_a, mul_b;
  logic signed [PW-1:0] prod_q, prod_d, prod_sh;
  logic                 mul_hit;
  logic signed [W-1:0]  mul_val;

  logic signed [W:0] sum_a, sum_e, sum_q1, sum_q2, sum_x, sum_y, sum_z;

  logic signed [36:0] col_prod, row_ext, row_prod;
  logic signed [39:0] col_p, row_p, col_c, row_c;
  logic               col_in, row_in;
  logic [W:0]         abs_x, abs_y, abs_z;
  logic [W+1:0]       move_sum;
  logic               coords_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q     <= lesp_pkg::RST_SIGMA;
      rho_q       <= lesp_pkg::RST_RHO;
      beta_q      <= lesp_pkg::RST_BETA;
      step_size_q <= lesp_pkg::RST_STEP;
      start_x_q   <= lesp_pkg::RST_START_X;
      start_y_q   <= lesp_pkg::RST_START_Y;
      start_z_q   <= lesp_pkg::RST_START_Z;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lesp_pkg::REG_SIGMA:     sigma_q     <= cfg_data_i;
        lesp_pkg::REG_RHO:       rho_q       <= cfg_data_i;
        lesp_pkg::REG_BETA:      beta_q      <= cfg_data_i;
        lesp_pkg::REG_STEP_SIZE: step_size_q <= cfg_data_i[lesp_pkg::STEP_W-1:0];
        lesp_pkg::REG_START_X:   start_x_q   <= cfg_data_i;
        lesp_pkg::REG_START_Y:   start_y_q   <= cfg_data_i;
        lesp_pkg::REG_START_Z:   start_z_q   <= cfg_data_i;
        default:                 ;
      endcase
    end
  end

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      lesp_pkg::MUL_X_Y: begin
        mul_a = (W+1)'(cur_x_q);
        mul_b = (W+1)'(cur_y_q);
      end
      lesp_pkg::MUL_SIGMA_A: begin
        mul_a = (W+1)'(sigma_q);
        mul_b = (W+1)'(a_q);
      end
      lesp_pkg::MUL_X_E: begin
        mul_a = (W+1)'(cur_x_q);
        mul_b = (W+1)'(e_q);
      end
      lesp_pkg::MUL_BETA_Z: begin
        mul_a = (W+1)'(beta_q);
        mul_b = (W+1)'(cur_z_q);
      end
      lesp_pkg::MUL_DT_T1: begin
        mul_a = $signed({{(W+1-lesp_pkg::STEP_W){1'b0}}, step_size_q});
        mul_b = (W+1)'(t1_q);
      end
      lesp_pkg::MUL_DT_Q1: begin
        mul_a = $signed({{(W+1-lesp_pkg::STEP_W){1'b0}}, step_size_q});
        mul_b = (W+1)'(q1_q);
      end
      lesp_pkg::MUL_DT_Q2: begin
        mul_a = $signed({{(W+1-lesp_pkg::STEP_W){1'b0}}, step_size_q});
        mul_b = (W+1)'(q2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor by arithmetic shift, then saturate
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign mul_hit = !((&prod_sh[PW-1:W-1]) || !(|prod_sh[PW-1:W-1]));
  assign mul_val = mul_hit ? (prod_sh[PW-1] ? lesp_pkg::SAT_MIN : lesp_pkg::SAT_MAX)
                           : prod_sh[W-1:0];

  assign sum_a  = (W+1)'(cur_y_q) - (W+1)'(cur_x_q);
  assign sum_e  = (W+1)'(rho_q)   - (W+1)'(cur_z_q);
  assign sum_q1 = (W+1)'(t2_q)    - (W+1)'(cur_y_q);
  assign sum_q2 = (W+1)'(t3_q)    - (W+1)'(t4_q);
  assign sum_x  = (W+1)'(cur_x_q) + (W+1)'(dx_q);
  assign sum_y  = (W+1)'(cur_y_q) + (W+1)'(dy_q);
  assign sum_z  = (W+1)'(cur_z_q) + (W+1)'(dz_q);

  // sticky saturation flag for the current item
  always_comb begin
    ovf_d = ovf_q;
    if (cmd_i.start) begin
      ovf_d = 1'b0;
    end else begin
      if (cmd_i.diff && (lesp_pkg::ovf33(sum_a) || lesp_pkg::ovf33(sum_e))) ovf_d = 1'b1;
      if (cmd_i.q1 && lesp_pkg::ovf33(sum_q1)) ovf_d = 1'b1;
      if (cmd_i.q2 && lesp_pkg::ovf33(sum_q2)) ovf_d = 1'b1;
      if ((cmd_i.wb_sel != lesp_pkg::WB_NONE) && mul_hit) ovf_d = 1'b1;
      if (cmd_i.update && (lesp_pkg::ovf33(sum_x) || lesp_pkg::ovf33(sum_y) ||
                           lesp_pkg::ovf33(sum_z))) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= lesp_pkg::RST_START_X;
      cur_y_q <= lesp_pkg::RST_START_Y;
      cur_z_q <= lesp_pkg::RST_START_Z;
      ovf_q   <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
      if (cmd_i.start && restart_i) begin
        cur_x_q <= start_x_q;
        cur_y_q <= start_y_q;
        cur_z_q <= start_z_q;
      end else if (cmd_i.update) begin
        cur_x_q <= lesp_pkg::sat33(sum_x);
        cur_y_q <= lesp_pkg::sat33(sum_y);
        cur_z_q <= lesp_pkg::sat33(sum_z);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      a_q <= lesp_pkg::sat33(sum_a);
      e_q <= lesp_pkg::sat33(sum_e);
    end
    if (cmd_i.q1) q1_q <= lesp_pkg::sat33(sum_q1);
    if (cmd_i.q2) q2_q <= lesp_pkg::sat33(sum_q2);
    case (cmd_i.wb_sel)
      lesp_pkg::WB_T1: t1_q <= mul_val;
      lesp_pkg::WB_T2: t2_q <= mul_val;
      lesp_pkg::WB_T3: t3_q <= mul_val;
      lesp_pkg::WB_T4: t4_q <= mul_val;
      lesp_pkg::WB_DX: dx_q <= mul_val;
      lesp_pkg::WB_DY: dy_q <= mul_val;
      lesp_pkg::WB_DZ: dz_q <= mul_val;
      default:         ;
    endcase
  end

  // pixel mapping: x*32 and y*18, floored, centered and clamped
  assign col_prod = 37'(cur_x_q) <<< 5;
  assign row_ext  = 37'(cur_y_q);
  assign row_prod = (row_ext <<< 4) + (row_ext <<< 1);
  assign col_p    = 40'(col_prod >>> FRAC_BITS) + ColCenter;
  assign row_p    = 40'(row_prod >>> FRAC_BITS) + RowCenter;

  always_comb begin
    col_in = 1'b1;
    col_c  = col_p;
    if (col_p < 0) begin
      col_in = 1'b0;
      col_c  = '0;
    end else if (col_p > ColLast) begin
      col_in = 1'b0;
      col_c  = ColLast;
    end
    row_in = 1'b1;
    row_c  = row_p;
    if (row_p < 0) begin
      row_in = 1'b0;
      row_c  = '0;
    end else if (row_p > RowLast) begin
      row_in = 1'b0;
      row_c  = RowLast;
    end
  end

  // motion measure over the exact deltas
  assign abs_x    = dx_q[W-1] ? (W+1)'(-(W+1)'(dx_q)) : (W+1)'(dx_q);
  assign abs_y    = dy_q[W-1] ? (W+1)'(-(W+1)'(dy_q)) : (W+1)'(dy_q);
  assign abs_z    = dz_q[W-1] ? (W+1)'(-(W+1)'(dz_q)) : (W+1)'(dz_q);
  assign move_sum = (W+2)'(abs_x) + (W+2)'(abs_y) + (W+2)'(abs_z);
  assign coords_ok = (48'(cur_x_q) <= CoordMax) && (48'(cur_y_q) <= CoordMax) &&
                     (48'(cur_z_q) <= CoordMax);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_o        <= cur_x_q;
      pos_y_o        <= cur_y_q;
      pos_z_o        <= cur_z_q;
      pixel_col_o    <= col_c[lesp_pkg::PIX_W-1:0];
      pixel_row_o    <= row_c[lesp_pkg::PIX_W-1:0];
      on_screen_o    <= col_in && row_in;
      still_moving_o <= (move_sum >= MoveMin) && coords_ok;
      overflowed_o   <= ovf_q;
    end
  end

endmodule

[rtl/core/lorenz_euler_step_plotter_core.sv]
// lorenz attractor stepper: each accepted item advances the stored point (x, y, z) by one
// forward-euler step, dx = dt*sigma*(y-x), dy = dt*(x*(rho-z)-y), dz = dt*(x*y-beta*z), in
// saturating signed q8.24 (FRAC_BITS fraction bits), and returns the new point, its screen
// pixel (x*32 + width/2, y*18 + height/2, floored and clamped) with an on-screen flag, a
// still-moving flag and a saturation flag; restart reloads the start point first. a new item is
// taken only once the previous one has walked all ten sequencer states and handed its result
// to the output register, with the sequencer back in idle: one shared 33x33 multiplier carries
// the seven products of a step, each product registered and then floored and saturated in the
// writeback of the following cycle. the result sits in an output register, so the next item is
// accepted while it waits; if it is still held when the next item finishes, the sequencer
// stalls in its last state and the input stays blocked. configuration is a plain write port
// (index 0 sigma .. 6 start_z) to be used while the block is idle.
`include "lorenz_euler_step_plotter_core_assert.svh"

module lorenz_euler_step_plotter_core #(
  parameter int unsigned FRAC_BITS     = 24,
  parameter int unsigned SCREEN_WIDTH  = 1920,
  parameter int unsigned SCREEN_HEIGHT = 1080
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [lesp_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lesp_pkg::DATA_W-1:0]         cfg_data_i,
  // input item
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  // result item
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lesp_pkg::DATA_W-1:0]  pos_x_o,
  output logic signed [lesp_pkg::DATA_W-1:0]  pos_y_o,
  output logic signed [lesp_pkg::DATA_W-1:0]  pos_z_o,
  output logic [lesp_pkg::PIX_W-1:0]          pixel_col_o,
  output logic [lesp_pkg::PIX_W-1:0]          pixel_row_o,
  output logic                                on_screen_o,
  output logic                                still_moving_o,
  output logic                                overflowed_o
);

  localparam logic signed [47:0] CoordMax = 48'sd100 <<< FRAC_BITS;

  lesp_pkg::cmd_t cmd;

  // sequencer: walks the multiply/writeback schedule and owns the result valid
  lesp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic, point state, config registers and result register
  lesp_dpath #(
    .FRAC_BITS     (FRAC_BITS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .restart_i      (restart_i),
    .cmd_i          (cmd),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .pixel_col_o    (pixel_col_o),
    .pixel_row_o    (pixel_row_o),
    .on_screen_o    (on_screen_o),
    .still_moving_o (still_moving_o),
    .overflowed_o   (overflowed_o)
  );

  // an accepted item keeps the block busy for the following cycle
  `LESP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                   !in_ready_o, "block ready right after accepting an item")

  // a new result appears exactly as the sequencer returns to idle
  `LESP_ASSERT_IMP(a_result_at_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o,
                   "result loaded while sequencer still busy")

  // still-moving results never carry a coordinate above the limit
  `LESP_ASSERT_IMP(a_moving_bound, clk_i, rst_ni, out_valid_o && still_moving_o,
                   (48'(pos_x_o) <= CoordMax) && (48'(pos_y_o) <= CoordMax) &&
                   (48'(pos_z_o) <= CoordMax),
                   "still_moving set with coordinate out of range")

endmodule

[dv/lorenz_plot_checker.sv]
`timescale 1ns / 1ps

module lorenz_plot_checker #(
  parameter int FRAC_BITS     = 24,
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lesp_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [lesp_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               restart_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [lesp_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [lesp_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [lesp_pkg::DATA_W-1:0] pos_z_i,
  input  logic [lesp_pkg::PIX_W-1:0]         pixel_col_i,
  input  logic [lesp_pkg::PIX_W-1:0]         pixel_row_i,
  input  logic                               on_screen_i,
  input  logic                               still_moving_i,
  input  logic                               overflowed_i,
  output int                                 pending_o,
  output int                                 fail_count_o
);
  import lesp_pkg::*;

  typedef logic signed [DATA_W-1:0] q24_t;

  typedef struct packed {
    q24_t             x;
    q24_t             y;
    q24_t             z;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             on_screen;
    logic             moving;
    logic             ovf;
  } plot_point_t;

  localparam int     COL_SCALE = 32;
  localparam int     ROW_SCALE = 18;
  localparam longint MOVE_MIN  = ((64'sd1 << FRAC_BITS) + 50) / 100;
  localparam longint COORD_MAX = 64'sd100 << FRAC_BITS;

  // register copies and the current point
  q24_t              k_sigma, k_rho, k_beta, org_x, org_y, org_z;
  logic [STEP_W-1:0] dt_raw;
  q24_t              pt_x, pt_y, pt_z;
  plot_point_t       expected_points[$];
  int                mismatches = 0;

  function automatic q24_t clip32(input longint v, inout bit hit);
    q24_t res;
    if (v > longint'(SAT_MAX)) begin
      hit = 1'b1;
      res = SAT_MAX;
    end else if (v < longint'(SAT_MIN)) begin
      hit = 1'b1;
      res = SAT_MIN;
    end else begin
      res = q24_t'(v);
    end
    return res;
  endfunction

  // product floored back to the fixed-point grid
  function automatic q24_t qmul(input longint a, input longint b, inout bit hit);
    return clip32((a * b) >>> FRAC_BITS, hit);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [PIX_W-1:0] to_pixel(input q24_t c, input int scale,
                                                input int span, inout bit seen);
    longint p;
    p = ((longint'(c) * scale) >>> FRAC_BITS) + span / 2;
    if (p < 0) begin
      seen = 1'b0;
      p = 0;
    end else if (p > span - 1) begin
      seen = 1'b0;
      p = span - 1;
    end
    return p[PIX_W-1:0];
  endfunction

  function automatic plot_point_t euler_step(input logic restart);
    longint      dt, moved;
    q24_t        x, y, z, p, q, r, dx, dy, dz;
    bit          hit, seen;
    plot_point_t res;
    if (restart) begin
      pt_x = org_x;
      pt_y = org_y;
      pt_z = org_z;
    end
    x    = pt_x;
    y    = pt_y;
    z    = pt_z;
    hit  = 1'b0;
    seen = 1'b1;
    dt   = longint'(dt_raw);

    p  = clip32(longint'(y) - longint'(x), hit);
    p  = qmul(k_sigma, p, hit);
    dx = qmul(dt, p, hit);

    p  = clip32(longint'(k_rho) - longint'(z), hit);
    p  = qmul(x, p, hit);
    q  = clip32(longint'(p) - longint'(y), hit);
    dy = qmul(dt, q, hit);

    p  = qmul(x, y, hit);
    r  = qmul(k_beta, z, hit);
    q  = clip32(longint'(p) - longint'(r), hit);
    dz = qmul(dt, q, hit);

    pt_x  = clip32(longint'(x) + longint'(dx), hit);
    pt_y  = clip32(longint'(y) + longint'(dy), hit);
    pt_z  = clip32(longint'(z) + longint'(dz), hit);
    moved = mag(dx) + mag(dy) + mag(dz);

    res.x         = pt_x;
    res.y         = pt_y;
    res.z         = pt_z;
    res.col       = to_pixel(pt_x, COL_SCALE, SCREEN_WIDTH, seen);
    res.row       = to_pixel(pt_y, ROW_SCALE, SCREEN_HEIGHT, seen);
    res.on_screen = seen;
    res.moving    = (moved >= MOVE_MIN) && (longint'(pt_x) <= COORD_MAX) &&
                    (longint'(pt_y) <= COORD_MAX) && (longint'(pt_z) <= COORD_MAX);
    res.ovf       = hit;
    return res;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    plot_point_t want;
    if (!rst_ni) begin
      k_sigma = RST_SIGMA;
      k_rho   = RST_RHO;
      k_beta  = RST_BETA;
      dt_raw  = RST_STEP;
      org_x   = RST_START_X;
      org_y   = RST_START_Y;
      org_z   = RST_START_Z;
      pt_x    = RST_START_X;
      pt_y    = RST_START_Y;
      pt_z    = RST_START_Z;
      expected_points.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_SIGMA:     k_sigma = cfg_data_i;
          REG_RHO:       k_rho   = cfg_data_i;
          REG_BETA:      k_beta  = cfg_data_i;
          REG_STEP_SIZE: dt_raw  = cfg_data_i[STEP_W-1:0];
          REG_START_X:   org_x   = cfg_data_i;
          REG_START_Y:   org_y   = cfg_data_i;
          REG_START_Z:   org_z   = cfg_data_i;
          default: ;
        endcase
      end
      // results first: a result leaving now belongs to an older item
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("result item with no item outstanding");
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          check_field("pos_x", want.x, pos_x_i);
          check_field("pos_y", want.y, pos_y_i);
          check_field("pos_z", want.z, pos_z_i);
          check_field("pixel_col", want.col, pixel_col_i);
          check_field("pixel_row", want.row, pixel_row_i);
          check_field("on_screen", want.on_screen, on_screen_i);
          check_field("still_moving", want.moving, still_moving_i);
          check_field("overflowed", want.ovf, overflowed_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_points.push_back(euler_step(restart_i));
      end
      pending_o    <= expected_points.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lesp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int FRAC         = 24;
  localparam int ONE          = 1 << FRAC;
  // comfortably longer than one pass through the sequencer states
  localparam int DRAIN_CYCLES = 16;
  // receiver hold-off, long enough to back the block up into its input
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LIMIT_NS     = 5_000_000;

  // no register lives at this index, writes must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] sigma, rho, beta, dt, sx, sy, sz;
  } lorenz_cfg_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0]    cfg_addr_i  = '0;
  logic [DATA_W-1:0]        cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic                     restart_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [PIX_W-1:0]         pixel_col_o, pixel_row_o;
  logic                     on_screen_o, still_moving_o, overflowed_o;

  int pending;
  int fail_count;

  // random idling on/off, and a toggle that asks the receiver for a long hold-off
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  lorenz_euler_step_plotter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .pixel_col_o    (pixel_col_o),
    .pixel_row_o    (pixel_row_o),
    .on_screen_o    (on_screen_o),
    .still_moving_o (still_moving_o),
    .overflowed_o   (overflowed_o)
  );

  // watches both channels and the write port, predicts every step and compares
  lorenz_plot_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_i        (pos_x_o),
    .pos_y_i        (pos_y_o),
    .pos_z_i        (pos_z_o),
    .pixel_col_i    (pixel_col_o),
    .pixel_row_i    (pixel_row_o),
    .on_screen_i    (on_screen_o),
    .still_moving_i (still_moving_o),
    .overflowed_i   (overflowed_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // write enable stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // all seven registers, then a stray write to the empty index
  task automatic load_config(input lorenz_cfg_t c);
    write_reg(REG_SIGMA, c.sigma);
    write_reg(REG_RHO, c.rho);
    write_reg(REG_BETA, c.beta);
    write_reg(REG_STEP_SIZE, c.dt);
    write_reg(REG_START_X, c.sx);
    write_reg(REG_START_Y, c.sy);
    write_reg(REG_START_Z, c.sz);
    write_reg(REG_UNUSED, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // offer one tick item, with an optional random gap first, and return once taken
  task automatic send_item(input logic restart);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      restart_i  <= $urandom_range(1);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // wait until every outstanding step has returned, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result side: random back-pressure, plus one long hold-off when asked
  initial begin : result_sink
    int  held;
    bit  last_req;
    last_req = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != last_req) begin
        last_req = hold_req;
        for (held = 0; held < LONG_HOLD; held++) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  initial begin : stimulus
    lorenz_cfg_t c;
    int          sent;
    int          phase;
    int          n;
    int          k;
    bit          wild;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: restart before any write, then let the point run
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    in_valid_i <= 1'b0;
    drain();

    // coefficients and start at the top/bottom limits, dt just under 2.0
    // with junk in the unused upper data bits
    c = '{SAT_MAX, SAT_MIN, SAT_MAX, 32'hFFFF_FFFF, SAT_MAX, SAT_MIN, SAT_MAX};
    load_config(c);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    in_valid_i <= 1'b0;
    drain();

    // mirrored limits with dt exactly 1.0
    c = '{SAT_MIN, SAT_MAX, SAT_MIN, ONE, SAT_MIN, SAT_MAX, SAT_MIN};
    load_config(c);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    in_valid_i <= 1'b0;
    drain();

    // everything zero: no motion, point parked at the screen center
    c = '{'0, '0, '0, '0, '0, '0, '0};
    load_config(c);
    send_item(1'b1);
    send_item(1'b0);
    in_valid_i <= 1'b0;
    drain();

    // off the right and bottom edges, z right on the 100 bound, tiniest dt
    c = '{RST_SIGMA, RST_RHO, RST_BETA, 32'd1, 30 * ONE, -32'sd511705088, 100 * ONE};
    load_config(c);
    send_item(1'b1);
    send_item(1'b0);
    in_valid_i <= 1'b0;
    drain();

    // negative sigma and beta near the lower-left screen corner
    c = '{-(10 * ONE), 28 * ONE, -ONE, ONE / 50, -(29 * ONE), -(29 * ONE), 5 * ONE};
    load_config(c);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    in_valid_i <= 1'b0;
    drain();

    // random phases: mostly attractor-like settings so trajectories evolve over
    // many steps, some with fully random registers that drive saturation
    sent = 0;
    for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
      wild = ($urandom_range(99) < 25);
      if (wild) begin
        c = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom()};
      end else begin
        c.sigma = $urandom_range(20 * ONE);
        c.rho   = $urandom_range(50 * ONE);
        c.beta  = $urandom_range(4 * ONE);
        c.dt    = $urandom_range(ONE / 50);
        c.sx    = int'($urandom_range(60 * ONE)) - 30 * ONE;
        c.sy    = int'($urandom_range(60 * ONE)) - 30 * ONE;
        c.sz    = $urandom_range(50 * ONE);
      end
      load_config(c);

      // one phase runs with no idling at all on either side
      idle_on <= (phase != 1);
      // another one has the receiver stall for a long stretch while items keep coming
      if (phase == 2) hold_req <= ~hold_req;

      n = $urandom_range(60, 140);
      for (k = 0; k < n; k++) begin
        if (k == 0) begin
          send_item($urandom_range(99) < 70);
        end else begin
          send_item($urandom_range(99) < 3);
        end
      end
      in_valid_i <= 1'b0;
      drain();
      sent += n;
    end

    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
